@@ sv/atd_pkg.sv @@
`default_nettype none

package atd_pkg;

	// Field and register widths
	localparam int SAMPLE_W = 12;
	localparam int BAND_W   = 10;
	localparam int DATA_W   = 16;
	localparam int USER_W   = 2;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 4;

	// Averaging window; its length must be a power of two so that the mean is a shift
	localparam int WINDOW_LEN = 8;
	localparam int WIN_BITS   = $clog2(WINDOW_LEN);
	localparam int TOTAL_W    = SAMPLE_W + WIN_BITS;

	// Largest running total the window can hold
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(WINDOW_LEN * ((1 << SAMPLE_W) - 1));

	// Signed width for the band comparisons, wide enough for threshold plus or minus band
	localparam int CMP_W = SAMPLE_W + 2;

	// Reset value of the band half width
	localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(50);

	// Register indexes (byte address divided by four)
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_BAND      = 2'd1;
	localparam logic [1:0] REG_RISE_EN   = 2'd2;
	localparam logic [1:0] REG_FALL_EN   = 2'd3;

	// Configuration as seen by the detector
	typedef struct packed {
		logic [SAMPLE_W-1:0] threshold;
		logic [BAND_W-1:0]   band;
		logic                rise_en;
		logic                fall_en;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic                ev_valid;
		logic                ev_rising;
	} result_t;

endpackage

`default_nettype wire

@@ sv/averaged_threshold_edge_detector_top.sv @@
`default_nettype none

// Moving-average threshold crossing detector. Each 12-bit converter sample taken on the
// slave stream enters a row of eight window cells, and a running total is updated by the
// new sample less the one leaving the far end of the row. The result on the master stream
// carries the truncated window mean in tdata and, in tuser, an event flag and its
// direction: an event is reported when the mean jumps from below threshold minus band to
// at or above threshold plus band (rising), or the mirror case (falling), each gated by its
// own enable. The block takes one sample every clock cycle while the master stream is not
// stalling; the running total is updated as each sample is accepted. An accepted sample
// waits in the first stage and its result is registered into the output stage once that
// stage is free. The window reads as all zeros after reset. Registers on the APB port: 0x0
// threshold, 0x4 band half width, 0x8 rising enable, 0xC falling enable; write them only
// while no sample is in flight.
module averaged_threshold_edge_detector_top
	import atd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Slave stream; tdata: sample [11:0], zero padding [15:12]
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,
	// Master stream; tdata: mean_value [11:0], zero padding [15:12]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [DATA_W-1:0] m_tdata,
	// tuser: event_valid [0], event_rising [1]
	output logic      [USER_W-1:0] m_tuser,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [SAMPLE_W-1:0] threshold_q;
	logic [BAND_W-1:0]   band_q;
	logic                rise_en_q;
	logic                fall_en_q;
	logic [1:0]          reg_idx;
	logic                cfg_wr;
	cfg_t                cfg;

	logic                s_accept;
	logic                out_ready;
	logic                load;
	logic                v_s1_q;
	logic                m_valid_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [SAMPLE_W-1:0] tap [WINDOW_LEN+1];
	result_t             res;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			band_q      <= BAND_RESET;
			rise_en_q   <= 1'b0;
			fall_en_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[SAMPLE_W-1:0];
				REG_BAND:      band_q      <= pwdata[BAND_W-1:0];
				REG_RISE_EN:   rise_en_q   <= pwdata[0];
				REG_FALL_EN:   fall_en_q   <= pwdata[0];
			endcase
		end
	end

	// Read-back of the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = {{(APB_DW-SAMPLE_W){1'b0}}, threshold_q};
			REG_BAND:      prdata = {{(APB_DW-BAND_W){1'b0}}, band_q};
			REG_RISE_EN:   prdata = {{(APB_DW-1){1'b0}}, rise_en_q};
			REG_FALL_EN:   prdata = {{(APB_DW-1){1'b0}}, fall_en_q};
		endcase
	end

	assign cfg.threshold = threshold_q;
	assign cfg.band      = band_q;
	assign cfg.rise_en   = rise_en_q;
	assign cfg.fall_en   = fall_en_q;

	// Handshake: the first stage frees up whenever its content can move to the output
	assign out_ready = !m_valid_q || m_tready;
	assign load      = v_s1_q && out_ready;
	assign s_tready  = !v_s1_q || out_ready;
	assign s_accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				v_s1_q <= 1'b1;
			end else if (load) begin
				v_s1_q <= 1'b0;
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Window row: each accepted sample pushes the oldest one out at the far end
	assign tap[0] = s_tdata[SAMPLE_W-1:0];

	for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
		atd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (s_accept),
			.d      (tap[k]),
			.q      (tap[k+1])
		);
	end

	// Running total: add the newcomer, drop the sample leaving the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (s_accept) begin
			total_q <= total_q - {{WIN_BITS{1'b0}}, tap[WINDOW_LEN]}
				+ {{WIN_BITS{1'b0}}, tap[0]};
		end
	end

	// Mean, band comparison and result register
	atd_detect u_detect (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.total  (total_q),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(DATA_W-SAMPLE_W){1'b0}}, res.mean};
	assign m_tuser  = {res.ev_rising, res.ev_valid};

	// The running total never exceeds a window full of full-scale samples.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_MAX)
		else $error("running total out of range");

	// A sample is only taken when the first stage is empty or handing on.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |-> (!v_s1_q || load))
		else $error("first stage overwritten");

	// Loading a result always raises the output valid in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ sv/atd_cell.sv @@
`default_nettype none

module atd_cell
	import atd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic [SAMPLE_W-1:0] d,
	output logic      [SAMPLE_W-1:0] q
);

	logic [SAMPLE_W-1:0] sample_q;

	// One window slot: takes its neighbour's sample whenever a new sample enters the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

`default_nettype wire

@@ sv/atd_detect.sv @@
`default_nettype none

module atd_detect
	import atd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic [TOTAL_W-1:0] total,
	input  wire cfg_t               cfg,
	output result_t                 res
);

	logic [SAMPLE_W-1:0]    mean;
	logic signed [CMP_W-1:0] lo;
	logic signed [CMP_W-1:0] hi;
	logic signed [CMP_W-1:0] m;
	logic signed [CMP_W-1:0] p;
	logic                    rise_hit;
	logic                    fall_hit;

	logic [SAMPLE_W-1:0] prev_mean_q;
	logic [SAMPLE_W-1:0] mean_s2;
	logic                ev_valid_s2;
	logic                ev_rising_s2;

	// Window mean: the total divided by the window length, a plain shift
	assign mean = total[TOTAL_W-1 -: SAMPLE_W];

	// Band edges and both means in a signed width that cannot wrap
	always_comb begin
		lo = $signed({2'b00, cfg.threshold}) - $signed({{(CMP_W-BAND_W){1'b0}}, cfg.band});
		hi = $signed({2'b00, cfg.threshold}) + $signed({{(CMP_W-BAND_W){1'b0}}, cfg.band});
		m  = $signed({2'b00, mean});
		p  = $signed({2'b00, prev_mean_q});
		rise_hit = cfg.rise_en && (p < lo) && (m >= hi);
		fall_hit = cfg.fall_en && (p > hi) && (m <= lo);
	end

	// Result register and the mean remembered for the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mean_q  <= '0;
			mean_s2      <= '0;
			ev_valid_s2  <= 1'b0;
			ev_rising_s2 <= 1'b0;
		end else if (load) begin
			prev_mean_q  <= mean;
			mean_s2      <= mean;
			ev_valid_s2  <= rise_hit || fall_hit;
			ev_rising_s2 <= rise_hit;
		end
	end

	assign res.mean      = mean_s2;
	assign res.ev_valid  = ev_valid_s2;
	assign res.ev_rising = ev_rising_s2;

	// A rising flag is only ever reported as part of an event.
	a_rising_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		ev_rising_s2 |-> ev_valid_s2)
		else $error("rising flag set without an event");

	// The stored previous mean always matches the mean just reported.
	a_prev_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		prev_mean_q == mean_s2)
		else $error("previous mean out of step with the result");

	// A rising event needs its enable to have been set when it was loaded.
	a_rise_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		load && rise_hit |=> ev_valid_s2 && ev_rising_s2 && $past(cfg.rise_en))
		else $error("rising event without enable");

endmodule

`default_nettype wire
